/* src/sacl_pkg.sv */
// shared constants and types for the set associative cache with true lru
// no dependencies
package sacl_pkg;
   localparam int NUM_SETS  = 64;
   localparam int NUM_WAYS  = 4;
   localparam int TAG_BITS  = 20;
   localparam int DATA_BITS = 32;
   localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_BITS  = $clog2(NUM_WAYS);
   localparam int AGE_BITS  = WAY_BITS;
   localparam int REQ_BITS  = SET_BITS + TAG_BITS + DATA_BITS;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [SET_BITS-1:0]  set_index;
      logic [TAG_BITS-1:0]  tag;
      logic [DATA_BITS-1:0] fill_data;
   } req_type;
endpackage

/* src/set_assoc_cache_lru_unit.sv */
// top level of the set associative cache with true lru replacement
// depends on sacl_pkg, sacl_front and sacl_back
// a request passes the front queue and then the back end's read state before its response turns valid
// the back end takes a new request only after its read and lru update and once its response is taken
// the front queue holds two requests so the request side keeps flowing while a response waits
// after reset a clearing pass over all 64 sets zeroes every valid bit and age, requests queue meanwhile
module set_assoc_cache_lru_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // set_index [5:0], tag [25:6], fill_data [57:26], zero pad to 64 bits
   input  logic [8*sacl_pkg::REQ_BYTES-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit [0], way [2:1], zero pad to 8 bits
   output logic [7:0] rsp_tdata
);
   sacl_pkg::req_type in_req, q_req;
   logic q_valid, q_ready;
   logic rsp_hit;
   logic [sacl_pkg::WAY_BITS-1:0] rsp_way;

   // unpack the request, first field in the lowest bits
   assign in_req.set_index = req_tdata[sacl_pkg::SET_BITS-1:0];
   assign in_req.tag = req_tdata[sacl_pkg::SET_BITS +: sacl_pkg::TAG_BITS];
   assign in_req.fill_data =
      req_tdata[sacl_pkg::SET_BITS + sacl_pkg::TAG_BITS +: sacl_pkg::DATA_BITS];

   sacl_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_req(in_req),
      .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
   );

   sacl_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
      .rsp_tvalid, .rsp_tready, .rsp_hit, .rsp_way
   );

   assign rsp_tdata = 8'({rsp_way, rsp_hit});
endmodule

/* src/sacl_front.sv */
// front end: accepts requests and buffers them in a short queue
// depends on sacl_pkg
module sacl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sacl_pkg::req_type in_req,
   output logic              out_valid,
   input  logic              out_ready,
   output sacl_pkg::req_type out_req
);
   sacl_pkg::req_type queue_ff [sacl_pkg::QUEUE_DEPTH];
   logic rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 2'(sacl_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_req   = queue_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= in_req;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(sacl_pkg::QUEUE_DEPTH)) else $error("queue overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1) else $error("push lost");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1) else $error("pop lost");
`endif
endmodule

/* src/sacl_back.sv */
// back end: lookup, replacement choice and lru update, one set per request
// depends on sacl_pkg
module sacl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  sacl_pkg::req_type               in_req,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_hit,
   output logic [sacl_pkg::WAY_BITS-1:0]   rsp_way
);
   localparam int W = sacl_pkg::NUM_WAYS;

   typedef struct packed {
      logic [W-1:0]                           valid;
      logic [W-1:0][sacl_pkg::AGE_BITS-1:0]   age;
   } lru_row_type;

   // lru state, one row per set: valid bits and ages of every way
   lru_row_type lru_mem [sacl_pkg::NUM_SETS];
   // tag memory, one row per set
   logic [sacl_pkg::TAG_BITS-1:0] tag_mem [sacl_pkg::NUM_SETS][W];
   logic [sacl_pkg::DATA_BITS-1:0] data_mem [sacl_pkg::NUM_SETS][W];

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RESP} state_type;
   state_type state_ff;
   sacl_pkg::req_type req_ff;
   logic [sacl_pkg::TAG_BITS-1:0] rd_tag_ff [W];
   lru_row_type row_ff;
   lru_row_type row_in;
   logic hit_ff;
   logic [sacl_pkg::WAY_BITS-1:0] way_ff;
   logic clr_busy_ff;
   logic [sacl_pkg::SET_BITS-1:0] clr_idx_ff;

   logic take;
   logic [sacl_pkg::SET_BITS-1:0] set_q;
   logic found;
   logic [sacl_pkg::WAY_BITS-1:0] hit_way, inv_way, old_way, sel_way;
   logic any_inv;
   logic [sacl_pkg::AGE_BITS:0] ref_age;
   logic [sacl_pkg::AGE_BITS-1:0] best_age;

   assign set_q    = req_ff.set_index;
   assign in_ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign take     = in_valid && in_ready;
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_hit  = hit_ff;
   assign rsp_way  = way_ff;

   always_comb begin
      found = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
      old_way = '0; best_age = row_ff.age[0];
      for (int i = W - 1; i >= 0; i--) begin
         if (row_ff.valid[i] && rd_tag_ff[i] == req_ff.tag) begin
            found = 1'b1; hit_way = sacl_pkg::WAY_BITS'(i);
         end
         if (!row_ff.valid[i]) begin
            any_inv = 1'b1; inv_way = sacl_pkg::WAY_BITS'(i);
         end
      end
      for (int i = 1; i < W; i++) begin
         if (row_ff.age[i] > best_age) begin
            best_age = row_ff.age[i];
            old_way  = sacl_pkg::WAY_BITS'(i);
         end
      end
      priority if (found) sel_way = hit_way;
      else if (any_inv) sel_way = inv_way;
      else sel_way = old_way;
      // an invalid way counts as older than every other
      if (!found && any_inv) ref_age = (sacl_pkg::AGE_BITS+1)'(W);
      else ref_age = {1'b0, row_ff.age[sel_way]};
      // new row: touched way youngest, younger valid ways age by one
      row_in = row_ff;
      for (int i = 0; i < W; i++) begin
         if (sacl_pkg::WAY_BITS'(i) == sel_way) begin
            row_in.age[i] = '0;
         end else if (row_ff.valid[i] && {1'b0, row_ff.age[i]} < ref_age &&
            row_ff.age[i] != sacl_pkg::AGE_BITS'(W - 1)) begin
            row_in.age[i] = row_ff.age[i] + 1'b1;
         end
      end
      row_in.valid[sel_way] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= in_req;
         row_ff <= lru_mem[in_req.set_index];
         for (int i = 0; i < W; i++) rd_tag_ff[i] <= tag_mem[in_req.set_index][i];
      end
      // one write per cycle: clearing pass after reset, else the lru update
      if (clr_busy_ff) begin
         lru_mem[clr_idx_ff] <= '0;
      end else if (state_ff == ST_READ) begin
         lru_mem[set_q] <= row_in;
      end
      if (state_ff == ST_READ && !found) begin
         tag_mem[set_q][sel_way]  <= req_ff.tag;
         data_mem[set_q][sel_way] <= req_ff.fill_data;
      end
      if (reset) begin
         state_ff    <= ST_IDLE;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         hit_ff <= 1'b0;
         way_ff <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == sacl_pkg::SET_BITS'(sacl_pkg::NUM_SETS - 1)) clr_busy_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: if (take) state_ff <= ST_READ;
            ST_READ: begin
               hit_ff   <= found;
               way_ff   <= sel_way;
               state_ff <= ST_RESP;
            end
            ST_RESP: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_touched_young: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> row_in.valid[sel_way] && row_in.age[sel_way] == '0)
      else $error("touched way not youngest");
   a_hit_way: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && found |-> row_ff.valid[hit_way])
      else $error("hit on invalid way");
   a_no_take_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !in_ready)
      else $error("request taken during clearing");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_hit) && $stable(rsp_way))
      else $error("response changed while waiting");
`endif
endmodule

/* tb/sv/tb.sv */
// self-checking testbench for set_assoc_cache_lru_unit
// depends on sacl_pkg and the rtl of the cache; holds its own lru cache predictor
module tb;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic             hit;
      logic [sacl_pkg::WAY_BITS-1:0] way;
   } lookup_type;

   // scoreboard: predicts hit and way for each request and keeps them in order
   class cache_scoreboard;
      bit                   valid_q [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
      logic [sacl_pkg::TAG_BITS-1:0] tag_q [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
      int unsigned          age_q   [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
      lookup_type           pending [$];
      int                   errors;

      function new();
         errors = 0;
         foreach (valid_q[s, w]) begin
            valid_q[s][w] = 0;
            tag_q[s][w]   = '0;
            age_q[s][w]   = 0;
         end
      endfunction

      // make way w the most recent, ageing younger valid ways
      function void promote(int s, int w, int unsigned old_age);
         for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
            if (i != w && valid_q[s][i] && age_q[s][i] < old_age &&
                age_q[s][i] < sacl_pkg::NUM_WAYS - 1)
               age_q[s][i]++;
         end
         age_q[s][w] = 0;
      endfunction

      function void note_request(sacl_pkg::req_type r);
         int s;
         int w;
         lookup_type e;
         s = r.set_index;
         w = -1;
         for (int i = 0; i < sacl_pkg::NUM_WAYS; i++)
            if (w < 0 && valid_q[s][i] && tag_q[s][i] == r.tag) w = i;
         if (w >= 0) begin
            promote(s, w, age_q[s][w]);
            e.hit = 1'b1;
         end else begin
            for (int i = 0; i < sacl_pkg::NUM_WAYS; i++)
               if (w < 0 && !valid_q[s][i]) w = i;
            if (w >= 0) begin
               promote(s, w, sacl_pkg::NUM_WAYS);
            end else begin
               w = 0;
               for (int i = 1; i < sacl_pkg::NUM_WAYS; i++)
                  if (age_q[s][i] > age_q[s][w]) w = i;
               promote(s, w, age_q[s][w]);
            end
            valid_q[s][w] = 1;
            tag_q[s][w]   = r.tag;
            e.hit = 1'b0;
         end
         e.way = sacl_pkg::WAY_BITS'(w);
         pending.push_back(e);
      endfunction

      function void check_response(logic [7:0] d);
         lookup_type e;
         if (pending.size() == 0) begin
            $error("unexpected response 0x%0h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[0] !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, d[0]);
            errors++;
         end
         if (d[2:1] !== e.way) begin
            $error("way: expected %0d actual %0d", e.way, d[2:1]);
            errors++;
         end
         if (d[7:3] !== '0) begin
            $error("pad: expected 0 actual %0h", d[7:3]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [8*sacl_pkg::REQ_BYTES-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;

   cache_scoreboard sb = new();
   int  send_idle_pct = 0;   // chance of an idle cycle on the request side
   int  recv_stall_pct = 0;  // chance of a stall cycle on the response side
   int  hold_off = 0;        // cycles of forced receiver stall still to run
   int  quiet_cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   set_assoc_cache_lru_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // receiver: random stalls, or a long hold-off while it is counted down
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one request, hold it until accepted
   task automatic send_request(logic [sacl_pkg::SET_BITS-1:0] s,
                               logic [sacl_pkg::TAG_BITS-1:0] t,
                               logic [sacl_pkg::DATA_BITS-1:0] d);
      sacl_pkg::req_type r;
      r.set_index = s;
      r.tag = t;
      r.fill_data = d;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(8*sacl_pkg::REQ_BYTES-sacl_pkg::REQ_BITS){1'b0}},
                     r.fill_data, r.tag, r.set_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
   endtask

   // random access with reuse of a small tag pool so hits and evictions are common
   task automatic send_random();
      logic [sacl_pkg::SET_BITS-1:0] s;
      logic [sacl_pkg::TAG_BITS-1:0] t;
      if ($urandom_range(3) == 0) s = sacl_pkg::SET_BITS'($urandom);
      else s = sacl_pkg::SET_BITS'($urandom_range(3));
      if ($urandom_range(4) == 0) t = sacl_pkg::TAG_BITS'($urandom);
      else t = {$urandom_range(1) ? 14'h3fff : 14'h0, 6'($urandom_range(6))};
      send_request(s, t, $urandom);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, fill of all ways, hits, then lru eviction
      send_request('0, '0, '0);
      send_request('1, '1, '1);
      send_request('0, '0, 32'h5555_5555);        // hit on way 0
      for (int i = 1; i < 6; i++)                  // fill and then evict in set 0
         send_request('0, sacl_pkg::TAG_BITS'(i), 32'hAAAA_AAAA);
      send_request('0, 20'd3, '1);                 // hit after eviction
      send_request('0, 20'd0, '0);                 // evicted tag misses again
      send_request('1, '1, '0);                    // hit in the top set
      for (int i = 0; i < 5; i++)
         send_request(6'd21, 20'hAAAAA ^ sacl_pkg::TAG_BITS'(i), '0);
      drain();

      // random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 34 : 0;
         recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 34 : 0;
         if (ph == 0) hold_off = 200;              // back pressure fills the queue
         for (int n = 0; n < 450; n++) send_random();
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
